[sv/osac_pkg.sv]
// constants, codes and microcode program of the oxygen sensor averaging block
package osac_pkg;

  localparam int WINDOW_DEF      = 256;
  localparam int SAMPLE_BITS_DEF = 10;

  localparam int REF_BITS     = 10;
  localparam int PCT_BITS     = 18;
  localparam int LOW_POINT    = 19;
  localparam int HIGH_POINT   = 96;
  localparam int SPAN         = HIGH_POINT - LOW_POINT;
  localparam int SPAN_BITS    = 7;
  localparam int CFG_IDX_BITS = 2;
  localparam int STEP_BITS    = 3;

  localparam logic [REF_BITS-1:0] REF_LOW_RST  = REF_BITS'(155);
  localparam logic [REF_BITS-1:0] REF_HIGH_RST = REF_BITS'(775);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_REF_LOW  = 2'd0,
    REG_REF_HIGH = 2'd1
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FILL  = 2'd1,
    ST_EQUAL = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_UPDATE,
    OP_CHECK,
    OP_DIV,
    OP_MAP,
    OP_LOAD,
    OP_FIX,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_NO_IN,
    COND_DIV_BUSY,
    COND_SKIP,
    COND_OUT_BLOCKED
  } cond_e;

  typedef struct packed {
    op_e                  op;
    cond_e                cond;
    logic [STEP_BITS-1:0] target;
  } ucode_t;

  localparam logic [STEP_BITS-1:0] STEP_WAIT    = 3'd0;
  localparam logic [STEP_BITS-1:0] STEP_UPDATE  = 3'd1;
  localparam logic [STEP_BITS-1:0] STEP_DIV     = 3'd5;
  localparam logic [STEP_BITS-1:0] STEP_EMIT    = 3'd7;

  // program rom: a taken condition jumps to target, else falls through to the next step
  function automatic ucode_t osac_ucode(input logic [STEP_BITS-1:0] step);
    ucode_t uc;
    case (step)
      3'd0:    uc = '{op: OP_WAIT,   cond: COND_NO_IN,       target: STEP_WAIT};
      3'd1:    uc = '{op: OP_UPDATE, cond: COND_NONE,        target: STEP_WAIT};
      3'd2:    uc = '{op: OP_CHECK,  cond: COND_SKIP,        target: STEP_EMIT};
      3'd3:    uc = '{op: OP_MAP,    cond: COND_NONE,        target: STEP_WAIT};
      3'd4:    uc = '{op: OP_LOAD,   cond: COND_NONE,        target: STEP_WAIT};
      3'd5:    uc = '{op: OP_DIV,    cond: COND_DIV_BUSY,    target: STEP_DIV};
      3'd6:    uc = '{op: OP_FIX,    cond: COND_NONE,        target: STEP_WAIT};
      3'd7:    uc = '{op: OP_EMIT,   cond: COND_OUT_BLOCKED, target: STEP_EMIT};
      default: uc = '{op: OP_WAIT,   cond: COND_NONE,        target: STEP_WAIT};
    endcase
    return uc;
  endfunction

endpackage

[sv/oxygen_sensor_average_calibrate.sv]
// oxygen sensor moving average with two-point linear calibration, microcoded
//
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  cfg      | cfg_valid_i cfg_ready_o cfg_index_i/data | write in
//  in       | in_valid_i in_ready_o sample_i           | item in
//  out      | out_valid_o out_ready_i percent_o status_o | item out
//
//  one item in flight; an item is taken only at program step zero
//  normal item: the program runs wait, update, check, map, load, divide, fix and emit in order;
//    the divide step is one pass of the one-bit-per-cycle restoring divider
//  window not filled or equal references: the divider is skipped, check jumps straight to emit
//  the average is the running sum shifted right, so WINDOW must be a power of two
//  reset clears the sum, position and filled flag; the ring needs no clearing
//    since an entry is only read back once the ring has wrapped
//  a waiting result sits in the output register; the program stalls at its last step
//    only if the previous result has still not been taken
module oxygen_sensor_average_calibrate #(
  parameter int WINDOW      = osac_pkg::WINDOW_DEF,
  parameter int SAMPLE_BITS = osac_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [osac_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [osac_pkg::REF_BITS-1:0]         cfg_data_i,
  // sample items
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [SAMPLE_BITS-1:0]                sample_i,
  // result items
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [osac_pkg::PCT_BITS-1:0]  percent_o,
  output logic [1:0]                            status_o
);
  import osac_pkg::*;

  // datapath widths
  localparam int PW        = $clog2(WINDOW);
  localparam int SUM_W     = SAMPLE_BITS + PW;
  localparam int OPR_W     = (SAMPLE_BITS > REF_BITS) ? SAMPLE_BITS : REF_BITS;
  localparam int DIFF_W    = OPR_W + 1;
  localparam int NUM_W     = DIFF_W + SPAN_BITS;
  localparam int NUM_MAG_W = NUM_W - 1;
  localparam int DIV_W     = NUM_MAG_W;
  localparam int DEN_W     = REF_BITS;
  localparam int CNT_W     = $clog2(DIV_W + 1);
  localparam int RES_W     = DIV_W + 2;

  localparam logic signed [NUM_W-1:0] SPAN_C = NUM_W'(SPAN);

  // sequencer
  logic [STEP_BITS-1:0] step_q, step_d;
  ucode_t               uc;
  logic                 take;

  // configuration
  logic [REF_BITS-1:0] ref_low_q, ref_low_d;
  logic [REF_BITS-1:0] ref_high_q, ref_high_d;

  // window state
  logic [SAMPLE_BITS-1:0] ring_mem [WINDOW];
  logic [SAMPLE_BITS-1:0] ring_rd_q;
  logic                   ring_we;
  logic [PW-1:0]          pos_q, pos_d;
  logic                   full_q, full_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [SAMPLE_BITS-1:0] avg;

  // restoring divider for the calibration quotient
  logic [DIV_W-1:0] dvd_q, dvd_d;
  logic [DEN_W-1:0] dvs_q, dvs_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DEN_W:0]   trial;
  logic             ge;

  // calibration operands
  logic signed [DIFF_W-1:0]   diff;
  logic signed [NUM_W-1:0]    num_q, num_d;
  logic signed [REF_BITS:0]   den_q, den_d;
  logic                       neg_q, neg_d;
  logic signed [NUM_W-1:0]    num_abs;
  logic signed [REF_BITS:0]   den_abs;
  logic signed [RES_W-1:0]    quot_s;
  logic signed [RES_W-1:0]    pct_full;
  logic signed [PCT_BITS-1:0] pct_q, pct_d;
  status_e                    st_q, st_d;

  // output register
  logic                       out_valid_q, out_valid_d;
  logic signed [PCT_BITS-1:0] percent_q, percent_d;
  logic [1:0]                 status_q, status_d;

  assign uc          = osac_ucode(step_q);
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (uc.op == OP_WAIT);
  assign out_valid_o = out_valid_q;
  assign percent_o   = percent_q;
  assign status_o    = status_q;

  // divider step
  assign trial = {rem_q, dvd_q[DIV_W-1]};
  assign ge    = (trial >= {1'b0, dvs_q});

  // entry under the write position only holds a sample once the ring has wrapped
  assign old_sample = full_q ? ring_rd_q : '0;

  // average = sum / window, a plain shift for a power-of-two window
  assign avg = sum_q[SUM_W-1:PW];

  assign diff    = DIFF_W'(signed'({1'b0, avg}))
                 - DIFF_W'(signed'({1'b0, ref_low_q}));
  assign num_abs = num_q[NUM_W-1] ? -num_q : num_q;
  assign den_abs = den_q[REF_BITS] ? -den_q : den_q;
  assign quot_s   = neg_q ? -RES_W'(dvd_q) : RES_W'(dvd_q);
  assign pct_full = quot_s + RES_W'(LOW_POINT);

  always_comb begin
    ref_low_d   = ref_low_q;
    ref_high_d  = ref_high_q;
    sample_d    = sample_q;
    pos_d       = pos_q;
    full_d      = full_q;
    sum_d       = sum_q;
    ring_we     = 1'b0;
    dvd_d       = dvd_q;
    dvs_d       = dvs_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    num_d       = num_q;
    den_d       = den_q;
    neg_d       = neg_q;
    pct_d       = pct_q;
    st_d        = st_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    percent_d   = percent_q;
    status_d    = status_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_REF_LOW:  ref_low_d  = cfg_data_i;
        REG_REF_HIGH: ref_high_d = cfg_data_i;
        default: ;
      endcase
    end

    case (uc.op)
      OP_WAIT: begin
        if (in_valid_i) begin
          sample_d = sample_i;
        end
      end
      OP_UPDATE: begin
        ring_we = 1'b1;
        sum_d   = sum_q - SUM_W'(old_sample) + SUM_W'(sample_q);
        if (pos_q == PW'(WINDOW - 1)) begin
          pos_d  = '0;
          full_d = 1'b1;
        end else begin
          pos_d = pos_q + PW'(1);
        end
      end
      OP_CHECK: begin
        if (!full_q) begin
          st_d = ST_FILL;
        end else if (ref_high_q == ref_low_q) begin
          st_d = ST_EQUAL;
        end else begin
          st_d = ST_OK;
        end
      end
      OP_DIV: begin
        rem_d = ge ? DEN_W'(trial - {1'b0, dvs_q}) : DEN_W'(trial);
        dvd_d = {dvd_q[DIV_W-2:0], ge};
        cnt_d = cnt_q - CNT_W'(1);
      end
      OP_MAP: begin
        num_d = NUM_W'(diff) * SPAN_C;
        den_d = signed'({1'b0, ref_high_q}) - signed'({1'b0, ref_low_q});
      end
      OP_LOAD: begin
        // truncating signed division as magnitudes plus a sign
        neg_d = num_q[NUM_W-1] ^ den_q[REF_BITS];
        dvd_d = DIV_W'(num_abs[NUM_MAG_W-1:0]);
        dvs_d = DEN_W'(den_abs[REF_BITS-1:0]);
        rem_d = '0;
        cnt_d = CNT_W'(DIV_W);
      end
      OP_FIX: begin
        // apply the sign and the low calibration point
        pct_d = pct_full[PCT_BITS-1:0];
      end
      OP_EMIT: begin
        if (!(out_valid_q && !out_ready_i)) begin
          out_valid_d = 1'b1;
          status_d    = st_q;
          percent_d   = (st_q == ST_OK) ? pct_q : '0;
        end
      end
      default: ;
    endcase
  end

  // branch condition of the current control word
  always_comb begin
    case (uc.cond)
      COND_NONE:        take = 1'b0;
      COND_NO_IN:       take = ~in_valid_i;
      COND_DIV_BUSY:    take = (cnt_q != CNT_W'(1));
      COND_SKIP:        take = (st_d != ST_OK);
      COND_OUT_BLOCKED: take = out_valid_q & ~out_ready_i;
      default:          take = 1'b0;
    endcase
    step_d = take ? uc.target : step_q + STEP_BITS'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_WAIT;
      ref_low_q   <= REF_LOW_RST;
      ref_high_q  <= REF_HIGH_RST;
      pos_q       <= '0;
      full_q      <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      ref_low_q   <= ref_low_d;
      ref_high_q  <= ref_high_d;
      pos_q       <= pos_d;
      full_q      <= full_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q  <= sample_d;
    dvd_q     <= dvd_d;
    dvs_q     <= dvs_d;
    rem_q     <= rem_d;
    cnt_q     <= cnt_d;
    num_q     <= num_d;
    den_q     <= den_d;
    neg_q     <= neg_d;
    pct_q     <= pct_d;
    st_q      <= st_d;
    percent_q <= percent_d;
    status_q  <= status_d;
  end

  // sample ring
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[pos_q] <= sample_q;
    end
    ring_rd_q <= ring_mem[pos_q];
  end

  // an accepted item always moves on to the ring update
  a_accept_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (step_q == STEP_UPDATE))
    else $error("accepted item did not reach the ring update");

  // once filled the window stays filled
  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(full_q))
    else $error("window filled flag dropped");

  // divider never iterates past its bit count
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uc.op == OP_DIV) |-> (cnt_q != '0))
    else $error("divider step with empty count");

  // restoring divider keeps the partial remainder below the divisor
  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uc.op == OP_DIV) |-> (rem_q < dvs_q))
    else $error("partial remainder not below divisor");

  // a result that is not valid carries a zero reading
  a_zero_pct: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != ST_OK)) |-> (percent_o == '0))
    else $error("nonzero reading with non-valid status");

endmodule
